// ===== rtl/jcws_pkg.sv =====
`default_nettype none
package jcws_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Scanner mode; code 7 is unused and scans as plain text
    typedef enum logic [2:0] {
        MODE_TEXT  = 3'd0,
        MODE_SLASH = 3'd1,
        MODE_LINE  = 3'd2,
        MODE_BLOCK = 3'd3,
        MODE_STAR  = 3'd4,
        MODE_STR   = 3'd5,
        MODE_DONE  = 3'd6
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       empty_res;
        logic       inside_string;
        logic       unterminated;
        logic       out_last;
    } out_item_t;

    // Outcome of scanning one input beat
    typedef struct packed {
        logic [1:0] count;
        out_item_t  item0;
        out_item_t  item1;
        mode_t      mode_next;
    } step_t;

endpackage
`default_nettype wire

// ===== rtl/jcws_step.sv =====
`default_nettype none
module jcws_step
    import jcws_pkg::*;
(
    input  wire mode_t    mode,
    input  wire in_item_t beat,
    output step_t         step
);

    logic [7:0] b;
    logic       blank;
    logic       fin;
    logic [1:0] n;
    logic [1:0] nm1;
    logic       unterm;
    logic       txt;
    mode_t      mode_n;
    out_item_t  it [2];

    assign b     = beat.in_byte;
    assign blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign fin   = (b == CH_NUL) || beat.in_last;

    always_comb
    begin
        mode_n = mode;
        n      = 2'd0;
        nm1    = 2'd0;
        unterm = 1'b0;
        txt    = 1'b0;
        it[0]  = '0;
        it[1]  = '0;
        if (mode == MODE_DONE)
        begin
            if (beat.in_last)
            begin
                mode_n = MODE_TEXT;
            end
        end
        else
        begin
            if (b != CH_NUL)
            begin
                case (mode)
                    MODE_SLASH:
                    begin
                        if (b == CH_SLASH)
                        begin
                            mode_n = MODE_LINE;
                        end
                        else if (b == CH_STAR)
                        begin
                            mode_n = MODE_BLOCK;
                        end
                        else
                        begin
                            // lone slash goes out as a plain character
                            it[0].out_byte = CH_SLASH;
                            n      = 2'd1;
                            mode_n = MODE_TEXT;
                            txt    = 1'b1;
                        end
                    end
                    MODE_LINE:
                    begin
                        if (b == CH_NL)
                        begin
                            mode_n = MODE_TEXT;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (b == CH_STAR)
                        begin
                            mode_n = MODE_STAR;
                        end
                    end
                    MODE_STAR:
                    begin
                        if (b == CH_SLASH)
                        begin
                            mode_n = MODE_TEXT;
                        end
                        else if (b != CH_STAR)
                        begin
                            mode_n = MODE_BLOCK;
                        end
                    end
                    MODE_STR:
                    begin
                        it[0].out_byte = b;
                        n = 2'd1;
                        if (b == CH_QUOTE)
                        begin
                            mode_n = MODE_TEXT;
                        end
                        else
                        begin
                            it[0].inside_string = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_n = MODE_TEXT;
                        txt    = 1'b1;
                    end
                endcase

                // plain text handling of the current byte
                if (txt && !blank)
                begin
                    if (b == CH_SLASH)
                    begin
                        mode_n = MODE_SLASH;
                    end
                    else
                    begin
                        it[n[0]].out_byte = b;
                        n = n + 2'd1;
                        if (b == CH_QUOTE)
                        begin
                            mode_n = MODE_STR;
                        end
                    end
                end
            end

            if (fin)
            begin
                if (mode_n == MODE_SLASH)
                begin
                    it[n[0]].out_byte = CH_SLASH;
                    n      = n + 2'd1;
                    mode_n = MODE_TEXT;
                end
                unterm = (mode_n == MODE_LINE) || (mode_n == MODE_BLOCK) ||
                         (mode_n == MODE_STAR) || (mode_n == MODE_STR);
                if (n == 2'd0)
                begin
                    it[0].empty_res = 1'b1;
                    n = 2'd1;
                end
                nm1 = n - 2'd1;
                it[nm1[0]].unterminated = unterm;
                it[nm1[0]].out_last     = 1'b1;
                mode_n = beat.in_last ? MODE_TEXT : MODE_DONE;
            end
        end
    end

    assign step.count     = n;
    assign step.item0     = it[0];
    assign step.item1     = it[1];
    assign step.mode_next = mode_n;

endmodule
`default_nettype wire

// ===== rtl/json_comment_whitespace_stripper_unit.sv =====
`default_nettype none
// JSON-with-comments stripper.
// Input channel (in_valid/in_ready/in_data): one raw text byte per beat, with
// in_last on the final byte of a buffer. Output channel (out_valid/out_ready/
// out_data): the significant characters, one per beat. White space, // and
// /* */ comments are dropped; string bodies pass raw with inside_string set.
// The final beat of a text carries out_last and the unterminated flag; if the
// ending byte produces no character, an empty end-marker beat is sent.
// A zero byte ends the text; bytes after it are swallowed up to in_last.
// An accepted character is written into the result queue that drives out_data.
// Throughput: one input beat per cycle. A held '/' that turns out not to open
// a comment yields two output beats from one input beat; these drain through
// a four-entry result queue, and in_ready drops while fewer than two entries
// are free. The scan mode register updates on every accepted beat.
// Reset empties the queue and puts the scanner in plain text mode.
// When the receiver stalls, the queue fills and in_ready falls once three
// entries are held; nothing is dropped.
module json_comment_whitespace_stripper_unit
    import jcws_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output out_item_t      out_data
);

    mode_t      mode_reg;
    mode_t      mode_next;
    step_t      step;
    out_item_t  q_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       in_fire;
    logic       pop;
    logic [1:0] push_n;

    jcws_step u_step (
        .mode (mode_reg),
        .beat (in_data),
        .step (step)
    );

    assign in_ready  = (count_reg <= 3'd2);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_n    = in_fire ? step.count : 2'd0;

    always_comb
    begin
        mode_next   = in_fire ? step.mode_next : mode_reg;
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_TEXT;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= step.item0;
        end
        if (push_n == 2'd2)
        begin
            q_reg[wr_ptr_reg + 2'd1] <= step.item1;
        end
    end

    // queue occupancy tracks pushes and pops
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) + {1'b0, $past(push_n)}
                  - {2'b00, $past(pop)}))
        else $error("queue count mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("queue overflow");

    // swallowed bytes after a zero byte produce nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (mode_reg == MODE_DONE)) |-> (step.count == 2'd0))
        else $error("output after end of text");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.empty_res) |-> out_data.out_last)
        else $error("empty beat without end mark");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.inside_string && out_data.out_last)
        |-> out_data.unterminated)
        else $error("open string not flagged");

endmodule
`default_nettype wire
